[rtl/vss_pkg.sv]
// Shared constants, codes and types for the versioned set with snapshot scan.
// No dependencies; every other file imports this package.
package vss_pkg;

	localparam int CAPACITY = 64;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int VER_W    = 32;

	localparam logic [VER_W-1:0] VERSION_MAX = 32'hFFFF_FFFE;

	localparam logic [1:0] REQ_ADD      = 2'd0;
	localparam logic [1:0] REQ_REMOVE   = 2'd1;
	localparam logic [1:0] REQ_CONTAINS = 2'd2;
	localparam logic [1:0] REQ_ENUM     = 2'd3;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FALSE = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef logic [SLOT_W-1:0] slot_idx_t;

	typedef struct packed {
		logic      rd_en;
		slot_idx_t rd_addr;
		slot_idx_t pres_addr;
	} store_rd_t;

	typedef struct packed {
		logic                     key_we;
		logic                     added_we;
		logic                     removed_we;
		logic                     set_present;
		logic                     clr_present;
		slot_idx_t                addr;
		logic signed [KEY_W-1:0]  key;
		logic [VER_W-1:0]         added;
		logic [VER_W-1:0]         removed;
	} store_wr_t;

	typedef struct packed {
		logic signed [KEY_W-1:0]  key;
		logic [VER_W-1:0]         added;
		logic [VER_W-1:0]         removed;
		logic                     present;
	} store_rsp_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [KEY_W-1:0]  key_out;
		logic                     key_valid;
		logic                     last;
		logic [VER_W-1:0]         version_now;
	} rsp_t;

endpackage

[rtl/vss_req_if.sv]
// Request channel: valid/ready handshake carrying one set request.
// Depends on vss_pkg for field widths.
interface vss_req_if import vss_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [1:0]              req_type;
	logic signed [KEY_W-1:0] key_in;
	logic [VER_W-1:0]        query_version;

	modport source (output valid, output req_type, output key_in, output query_version,
		input ready);
	modport sink (input valid, input req_type, input key_in, input query_version,
		output ready);
endinterface

[rtl/vss_rsp_if.sv]
// Result channel: valid/ready handshake carrying one result item.
// Depends on vss_pkg for field widths.
interface vss_rsp_if import vss_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [1:0]              status;
	logic signed [KEY_W-1:0] key_out;
	logic                    key_valid;
	logic                    last;
	logic [VER_W-1:0]        version_now;

	modport source (output valid, output status, output key_out, output key_valid,
		output last, output version_now, input ready);
	modport sink (input valid, input status, input key_out, input key_valid,
		input last, input version_now, output ready);
endinterface

[rtl/vss_slot_store.sv]
// Slot storage: key and version memories with a registered read port,
// plus the per-slot present bits. Depends on vss_pkg.
module vss_slot_store import vss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  store_rd_t  rd,
	input  store_wr_t  wr,
	output store_rsp_t rsp
);

	logic signed [KEY_W-1:0] mem_key     [CAPACITY];
	logic [VER_W-1:0]        mem_added   [CAPACITY];
	logic [VER_W-1:0]        mem_removed [CAPACITY];
	logic [CAPACITY-1:0]     present_q;
	logic signed [KEY_W-1:0] key_q;
	logic [VER_W-1:0]        added_q;
	logic [VER_W-1:0]        removed_q;

	always_ff @(posedge clk) begin
		if (wr.key_we) begin
			mem_key[wr.addr] <= wr.key;
		end
		if (wr.added_we) begin
			mem_added[wr.addr] <= wr.added;
		end
		if (wr.removed_we) begin
			mem_removed[wr.addr] <= wr.removed;
		end
		if (rd.rd_en) begin
			key_q     <= mem_key[rd.rd_addr];
			added_q   <= mem_added[rd.rd_addr];
			removed_q <= mem_removed[rd.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
		end else if (wr.set_present) begin
			present_q[wr.addr] <= 1'b1;
		end else if (wr.clr_present) begin
			present_q[wr.addr] <= 1'b0;
		end
	end

	assign rsp.key     = key_q;
	assign rsp.added   = added_q;
	assign rsp.removed = removed_q;
	assign rsp.present = present_q[rd.pres_addr];

endmodule

[rtl/vss_seq.sv]
// Request sequencer: slot scan, key and liveness compare, version counter
// and the final update of each request. Depends on vss_pkg.
module vss_seq import vss_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              in_req_type,
	input  logic signed [KEY_W-1:0] in_key,
	input  logic [VER_W-1:0]        in_query_version,
	input  logic                    out_free,
	output logic                    push_valid,
	output rsp_t                    push,
	output store_rd_t               rd,
	output store_wr_t               wr,
	input  store_rsp_t              rsp
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t                  state_q;
	logic [1:0]              req_q;
	logic signed [KEY_W-1:0] key_q;
	logic [VER_W-1:0]        qv_q;
	logic [CNT_W-1:0]        ptr_q;
	logic [CNT_W-1:0]        count_q;
	logic [VER_W-1:0]        ver_q;
	logic                    valid_s1;
	slot_idx_t               idx_s1;
	logic                    found_q;
	slot_idx_t               found_idx_q;
	logic                    pend_valid_q;
	logic signed [KEY_W-1:0] pend_key_q;

	logic             is_enum;
	logic             hit;
	logic             live;
	logic             stall;
	logic             issue;
	logic             scan_done;
	logic             push_scan;
	logic             fin_go;
	logic             full;
	logic             claim;
	logic [VER_W-1:0] ver_bump;
	logic [1:0]       fin_status;
	logic [VER_W-1:0] fin_ver;

	assign is_enum   = (req_q == REQ_ENUM);
	assign hit       = (state_q == ST_SCAN) && valid_s1 && !is_enum && (rsp.key == key_q);
	assign live      = (state_q == ST_SCAN) && valid_s1 && is_enum && (rsp.added <= qv_q)
		&& (rsp.present || (rsp.removed > qv_q));
	assign stall     = live && pend_valid_q && !out_free;
	assign issue     = (state_q == ST_SCAN) && (ptr_q != count_q) && !hit && !stall;
	assign scan_done = (state_q == ST_SCAN) && (ptr_q == count_q) && !hit && !stall;
	assign push_scan = live && pend_valid_q && out_free;
	assign fin_go    = (state_q == ST_FINISH) && out_free;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign ver_bump  = (ver_q == VERSION_MAX) ? ver_q : ver_q + 1'b1;
	assign in_ready  = (state_q == ST_IDLE);

	assign rd.rd_en     = issue;
	assign rd.rd_addr   = ptr_q[SLOT_W-1:0];
	assign rd.pres_addr = (state_q == ST_FINISH) ? found_idx_q : idx_s1;

	always_comb begin
		wr          = '0;
		wr.addr     = found_idx_q;
		wr.key      = key_q;
		wr.added    = ver_bump;
		wr.removed  = '0;
		fin_status  = STATUS_FALSE;
		fin_ver     = ver_q;
		claim       = 1'b0;
		case (req_q)
			REQ_ADD: begin
				fin_ver = ver_bump;
				if (found_q) begin
					if (!rsp.present) begin
						fin_status     = STATUS_OK;
						wr.added_we    = fin_go;
						wr.removed_we  = fin_go;
						wr.set_present = fin_go;
					end
				end else if (!full) begin
					fin_status     = STATUS_OK;
					claim          = fin_go;
					wr.addr        = count_q[SLOT_W-1:0];
					wr.key_we      = fin_go;
					wr.added_we    = fin_go;
					wr.removed_we  = fin_go;
					wr.set_present = fin_go;
				end else begin
					fin_status = STATUS_FULL;
				end
			end
			REQ_REMOVE: begin
				if (found_q && rsp.present) begin
					fin_status     = STATUS_OK;
					fin_ver        = ver_bump;
					wr.removed     = ver_bump;
					wr.removed_we  = fin_go;
					wr.clr_present = fin_go;
				end
			end
			REQ_CONTAINS: begin
				if (found_q && rsp.present) begin
					fin_status = STATUS_OK;
				end
			end
			default: begin
				if (pend_valid_q) begin
					fin_status = STATUS_OK;
				end
			end
		endcase
	end

	always_comb begin
		push_valid = push_scan || fin_go;
		if (push_scan) begin
			push.status      = STATUS_OK;
			push.key_out     = pend_key_q;
			push.key_valid   = 1'b1;
			push.last        = 1'b0;
			push.version_now = ver_q;
		end else begin
			push.status      = fin_status;
			push.key_out     = (is_enum && pend_valid_q) ? pend_key_q : '0;
			push.key_valid   = is_enum && pend_valid_q;
			push.last        = 1'b1;
			push.version_now = fin_ver;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ptr_q        <= '0;
			count_q      <= '0;
			ver_q        <= '0;
			valid_s1     <= 1'b0;
			found_q      <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q      <= ST_SCAN;
						ptr_q        <= '0;
						valid_s1     <= 1'b0;
						found_q      <= 1'b0;
						pend_valid_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						found_q  <= 1'b1;
						valid_s1 <= 1'b0;
						state_q  <= ST_FINISH;
					end else if (!stall) begin
						valid_s1 <= issue;
						if (issue) begin
							ptr_q <= ptr_q + 1'b1;
						end
						if (live) begin
							pend_valid_q <= 1'b1;
						end
						if (scan_done) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					if (fin_go) begin
						ver_q   <= fin_ver;
						state_q <= ST_IDLE;
						if (claim) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= in_req_type;
			key_q <= in_key;
			qv_q  <= in_query_version;
		end
		if (issue) begin
			idx_s1 <= ptr_q[SLOT_W-1:0];
		end
		if (hit) begin
			found_idx_q <= idx_s1;
		end
		if (live && !stall) begin
			pend_key_q <= rsp.key;
		end
	end

endmodule

[rtl/versioned_set_with_snapshot_scan.sv]
// A set of up to CAPACITY signed 32-bit keys with a saturating version counter. Each
// request (add, remove, contains, enumerate) scans the filled slots in order, one slot a
// cycle while the scan is not stalled, through the single read port of the slot memories, then
// applies its update in a finish state. An add, remove or contains that finds its key stops
// scanning early. Enumerate results can be held back by output backpressure, which stalls the scan.
// No new request is taken until the current one has placed its last result in the output
// register. Top level; depends on vss_pkg, vss_req_if, vss_rsp_if, vss_slot_store, vss_seq.
module versioned_set_with_snapshot_scan import vss_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	vss_req_if.sink  req,
	vss_rsp_if.source rsp
);

	store_rd_t  st_rd;
	store_wr_t  st_wr;
	store_rsp_t st_rsp;
	logic       push_valid;
	rsp_t       push;
	logic       out_free;
	logic       out_valid_q;
	rsp_t       out_q;

	assign out_free = !out_valid_q || rsp.ready;

	vss_slot_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (st_rd),
		.wr     (st_wr),
		.rsp    (st_rsp)
	);

	vss_seq u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (req.valid),
		.in_ready         (req.ready),
		.in_req_type      (req.req_type),
		.in_key           (req.key_in),
		.in_query_version (req.query_version),
		.out_free         (out_free),
		.push_valid       (push_valid),
		.push             (push),
		.rd               (st_rd),
		.wr               (st_wr),
		.rsp              (st_rsp)
	);

	// hold a result until its transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_valid) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid) begin
			out_q <= push;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_q.status;
	assign rsp.key_out     = out_q.key_out;
	assign rsp.key_valid   = out_q.key_valid;
	assign rsp.last        = out_q.last;
	assign rsp.version_now = out_q.version_now;

endmodule
